@@ hdl/mmlq_pkg.sv @@
// Shared types and constants of the min/max level quantizer.
// No dependencies.
`default_nettype none
package mmlq_pkg;

  localparam int unsigned LEVEL_BITS   = 9;
  localparam int unsigned CODE_BITS    = 8;
  localparam int unsigned QUO_BITS     = 9;
  localparam int unsigned STEP_BITS    = $clog2(QUO_BITS);
  localparam int unsigned MAX_LEVELS   = 256;
  localparam logic [LEVEL_BITS-1:0] LEVELS_RESET = LEVEL_BITS'(3);

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_READ = 7'b0000010,
    S_OFF  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FMT  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic store;
    logic off;
    logic mul;
    logic step;
    logic fmt;
    logic next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/mmlq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mmlq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ hdl/mmlq_datapath.sv @@
// Datapath: sample buffer, running min/max, offset multiply, restoring divider, code register.
// Depends on mmlq_pkg and mmlq_ram.
`default_nettype none
module mmlq_datapath #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mmlq_pkg::LEVEL_BITS-1:0]   cfg_wdata_i,
  input  wire logic [SAMPLE_BITS-1:0]            sample_i,
  input  wire mmlq_pkg::cmd_t                    cmd_i,
  output mmlq_pkg::status_t                      sts_o,
  output logic      [mmlq_pkg::CODE_BITS-1:0]    level_code_o,
  output logic                                   last_code_o
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned LB = mmlq_pkg::LEVEL_BITS;
  localparam int unsigned QB = mmlq_pkg::QUO_BITS;
  localparam int unsigned PB = SAMPLE_BITS + QB;

  logic [LB-1:0]                    nlev_q;
  logic [CW-1:0]                    count_q, count_d;
  logic [AW-1:0]                    idx_q;
  logic signed [SAMPLE_BITS-1:0]    min_q, max_q, smp;
  logic [SAMPLE_BITS-1:0]           rdata;
  logic [SAMPLE_BITS-1:0]           off_q, span_q, rem_q;
  logic [QB-1:0]                    quo_q;
  logic [mmlq_pkg::STEP_BITS-1:0]   step_q;
  logic [mmlq_pkg::CODE_BITS-1:0]   code_q;
  logic                             last_q;
  logic [LB-1:0]                    lev;
  logic                             room, we, last;
  logic [SAMPLE_BITS:0]             off_w, span_w, trial, diff;
  logic                             ge;
  logic [PB-1:0]                    prod;
  logic [LB-1:0]                    code_w;

  assign smp  = sample_i;
  assign room = count_q < CW'(MAX_SAMPLES);
  assign we   = cmd_i.store && room;
  assign last = (CW'(idx_q) + CW'(1)) == count_q;

  // zero levels act as one, anything above the alphabet size saturates
  always_comb begin
    if (nlev_q == '0) begin
      lev = LB'(1);
    end else if (nlev_q > LB'(mmlq_pkg::MAX_LEVELS)) begin
      lev = LB'(mmlq_pkg::MAX_LEVELS);
    end else begin
      lev = nlev_q;
    end
  end

  mmlq_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(sample_i),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (we) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nlev_q  <= mmlq_pkg::LEVELS_RESET;
      count_q <= '0;
      idx_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        nlev_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (cmd_i.clear) begin
        idx_q <= '0;
      end else if (cmd_i.next) begin
        idx_q <= idx_q + AW'(1);
      end
      if (we) begin
        if (count_q == '0) begin
          min_q <= smp;
          max_q <= smp;
        end else if (smp < min_q) begin
          min_q <= smp;
        end else if (smp > max_q) begin
          max_q <= smp;
        end
      end
    end
  end

  // offsets are never negative and fit the sample width unsigned
  assign off_w  = {rdata[SAMPLE_BITS-1], rdata} - {min_q[SAMPLE_BITS-1], min_q};
  assign span_w = {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};
  assign prod   = PB'(off_q) * PB'(lev);

  // one restoring step: shift in next numerator bit, subtract span if it fits
  assign trial = {rem_q, quo_q[QB-1]};
  assign ge    = trial >= {1'b0, span_q};
  assign diff  = trial - {1'b0, span_q};

  always_comb begin
    if (span_q == '0) begin
      code_w = '0;
    end else if (quo_q > (lev - LB'(1))) begin
      code_w = lev - LB'(1);
    end else begin
      code_w = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.mul) begin
      step_q <= '0;
    end else if (cmd_i.step) begin
      step_q <= step_q + mmlq_pkg::STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.off) begin
      off_q  <= off_w[SAMPLE_BITS-1:0];
      span_q <= span_w[SAMPLE_BITS-1:0];
    end
    if (cmd_i.mul) begin
      // product < span * 2^QB, so the high part already sits below the divisor
      {rem_q, quo_q} <= prod;
    end else if (cmd_i.step) begin
      rem_q <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      quo_q <= {quo_q[QB-2:0], ge};
    end
    if (cmd_i.fmt) begin
      code_q <= code_w[mmlq_pkg::CODE_BITS-1:0];
      last_q <= last;
    end
  end

  assign sts_o.div_done = step_q == mmlq_pkg::STEP_BITS'(QB - 1);
  assign sts_o.last     = last_q;
  assign level_code_o   = code_q;
  assign last_code_o    = last_q;

endmodule
`default_nettype wire

@@ hdl/mmlq_ctrl.sv @@
// Controller FSM: load phase, then read/offset/multiply/divide/format/output per code.
// Depends on mmlq_pkg.
`default_nettype none
module mmlq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               end_i,
  input  wire logic               out_stall_i,
  input  wire mmlq_pkg::status_t  sts_i,
  output mmlq_pkg::cmd_t          cmd_o,
  output logic                    in_stall_o,
  output logic                    out_valid_o
);

  mmlq_pkg::state_e state_q, state_d;
  logic             in_fire;

  assign in_stall_o  = state_q != mmlq_pkg::S_LOAD;
  assign out_valid_o = state_q == mmlq_pkg::S_OUT;
  assign in_fire     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      mmlq_pkg::S_LOAD: begin
        if (in_fire) begin
          cmd_o.store = 1'b1;
          if (end_i) begin
            state_d = mmlq_pkg::S_READ;
          end
        end
      end
      mmlq_pkg::S_READ: begin
        state_d = mmlq_pkg::S_OFF;
      end
      mmlq_pkg::S_OFF: begin
        cmd_o.off = 1'b1;
        state_d   = mmlq_pkg::S_MUL;
      end
      mmlq_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = mmlq_pkg::S_DIV;
      end
      mmlq_pkg::S_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_done) begin
          state_d = mmlq_pkg::S_FMT;
        end
      end
      mmlq_pkg::S_FMT: begin
        cmd_o.fmt = 1'b1;
        state_d   = mmlq_pkg::S_OUT;
      end
      mmlq_pkg::S_OUT: begin
        if (!out_stall_i) begin
          if (sts_i.last) begin
            cmd_o.clear = 1'b1;
            state_d     = mmlq_pkg::S_LOAD;
          end else begin
            cmd_o.next = 1'b1;
            state_d    = mmlq_pkg::S_READ;
          end
        end
      end
      default: begin
        state_d = mmlq_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmlq_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_end_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_i) |=> (state_q == mmlq_pkg::S_READ))
    else $error("end of series did not start code emission");
  a_stall_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sts_i.last)))
    else $error("stalled code was dropped or changed");
  a_div_to_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mmlq_pkg::S_DIV && sts_i.div_done) |=> (state_q == mmlq_pkg::S_FMT))
    else $error("divider finish not followed by format");
`endif

endmodule
`default_nettype wire

@@ hdl/min_max_level_quantizer.sv @@
// Min/max level quantizer: samples are taken one per cycle while loading (no results).
// After the end-of-series sample, codes are emitted one by one, each through RAM read,
// offset, multiply, 9-step restoring divide, format and output; a stalled output holds its
// code. No input is taken while codes are emitted.
// Reset (async, active low) empties the series, zeroes min/max and sets n_levels to 3;
// the sample buffer itself is not cleared, only entries of the current series are read.
// Depends on mmlq_pkg, mmlq_ctrl, mmlq_datapath and mmlq_ram.
`default_nettype none
module min_max_level_quantizer #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // register write: n_levels
  input  wire logic                            cfg_we_i,
  input  wire logic [mmlq_pkg::LEVEL_BITS-1:0] cfg_wdata_i,
  // input items
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]          sample_i,
  input  wire logic                            end_of_series_i,
  // result items
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [mmlq_pkg::CODE_BITS-1:0]  level_code_o,
  output logic                                 last_code_o
);

  mmlq_pkg::cmd_t    cmd;
  mmlq_pkg::status_t sts;

  // sequencing: load phase accepts items, emit phase walks the buffer in order
  mmlq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .end_i      (end_of_series_i),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  // storage, running min/max and the per-code arithmetic
  mmlq_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .level_code_o(level_code_o),
    .last_code_o (last_code_o)
  );

endmodule
`default_nettype wire
